// ----- rtl/lsh_pkg.sv -----
// Package for the 3x3 Laplacian sharpening block: field widths, register
// indexes and the pixel and result types. No dependencies.
package lsh_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned CoordW  = 10;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CfgW-1:0] WIDTH_RESET  = 11'd320;
  localparam logic [CfgW-1:0] HEIGHT_RESET = 11'd240;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t              rgb;
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic              frame_last;
  } lsh_result_t;

endpackage

// ----- rtl/lsh_if.sv -----
// Streaming channel interfaces for the sharpening block: input pixels and
// filtered results. Depends on lsh_pkg.
interface lsh_pix_if import lsh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red_in;
  logic [ChanW-1:0] green_in;
  logic [ChanW-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                output ready);
endinterface

interface lsh_res_if import lsh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ChanW-1:0]  red_out;
  logic [ChanW-1:0]  green_out;
  logic [ChanW-1:0]  blue_out;
  logic [CoordW-1:0] pixel_x;
  logic [CoordW-1:0] pixel_y;
  logic              frame_last;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output pixel_x, output pixel_y, output frame_last, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input pixel_x, input pixel_y, input frame_last, output ready);
endinterface

// ----- rtl/laplacian_sharpen_3x3_rgb.sv -----
// Top level of the 3x3 Laplacian sharpening filter for RGB raster streams.
// Depends on lsh_pkg, lsh_if, lsh_ram, lsh_kernel and lsh_skid.
//
//   Channel   Dir  Modport  Transaction carries
//   pix_i     in   sink     red_in, green_in, blue_in (one raster pixel)
//   res_o     out  source   red_out, green_out, blue_out, pixel_x, pixel_y,
//                           frame_last (one filtered interior pixel)
//   cfg_*     in   -        cfg_idx_i selects image_width or image_height
//
// One pixel transaction is accepted per clock while pix_i.ready is high. Its result,
// if any, is registered at the accepting edge, into the skid entry if the output
// stalls; the kernel sits between the line-store read registers and the output register.
// Reset clears the counters, window and handshake state at once; the line
// stores are not cleared and need no clearing pass.
// A stalled output holds one result and buffers a second in a skid entry;
// pix_i.ready drops only while that skid entry is occupied.
module laplacian_sharpen_3x3_rgb import lsh_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  lsh_pix_if.sink            pix_i,
  lsh_res_if.source          res_o
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT);
  localparam int unsigned MaxW = (ColW > RowW) ? ColW + 1 : RowW + 1;
  localparam int unsigned CmpW = (MaxW > CfgW) ? MaxW : CfgW;

  // Size registers, reset to the default frame size.
  logic [CfgW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective sizes are clamped to at least 3 and at most MAX_WIDTH or MAX_HEIGHT.
  logic [CmpW-1:0] w_eff, h_eff;

  always_comb begin
    w_eff = CmpW'(width_q);
    if (w_eff < CmpW'(3)) begin
      w_eff = CmpW'(3);
    end else if (w_eff > CmpW'(MAX_WIDTH)) begin
      w_eff = CmpW'(MAX_WIDTH);
    end
    h_eff = CmpW'(height_q);
    if (h_eff < CmpW'(3)) begin
      h_eff = CmpW'(3);
    end else if (h_eff > CmpW'(MAX_HEIGHT)) begin
      h_eff = CmpW'(MAX_HEIGHT);
    end
  end

  // Raster position of the next input pixel.
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            accept, in_ready, col_last, row_last, emit;

  assign accept   = pix_i.valid && in_ready;
  assign col_last = (CmpW'(col_q) + CmpW'(1)) == w_eff;
  assign row_last = (CmpW'(row_q) + CmpW'(1)) == h_eff;
  assign emit     = (col_q >= ColW'(2)) && (row_q >= RowW'(2));

  // Any register write restarts the frame at the top left corner.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line stores. The read address runs one step ahead: it follows the next
  // column count, so the registered read data always belongs to the column of
  // the pixel waiting to be accepted. On a pixel write outside a register write it
  // differs from the write address, because a row holds at least three pixels.
  rgb_t px, top, mid;

  assign px = '{red: pix_i.red_in, green: pix_i.green_in, blue: pix_i.blue_in};

  lsh_ram #(.WIDTH($bits(rgb_t)), .DEPTH(MAX_WIDTH)) u_upper_line (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (mid),
    .raddr_i (col_d),
    .rdata_o (top)
  );

  lsh_ram #(.WIDTH($bits(rgb_t)), .DEPTH(MAX_WIDTH)) u_lower_line (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (px),
    .raddr_i (col_d),
    .rdata_o (mid)
  );

  // Window: two older columns, each top, middle, bottom.
  rgb_t win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) begin
        win_q[k] <= '0;
      end
    end else if (accept) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= px;
    end
  end

  // The newest column comes straight from the line-store read registers and
  // the input pixel.
  rgb_t win [9];
  rgb_t sharp;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      win[k] = win_q[k];
    end
    win[6] = top;
    win[7] = mid;
    win[8] = px;
  end

  lsh_kernel u_kernel (
    .win_i (win),
    .pix_o (sharp)
  );

  lsh_result_t res, res_out;
  logic        out_valid;

  assign res.rgb        = sharp;
  assign res.pixel_x    = CoordW'(col_q) - CoordW'(1);
  assign res.pixel_y    = CoordW'(row_q) - CoordW'(1);
  assign res.frame_last = col_last && row_last;

  lsh_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept && emit),
    .in_data_i   (res),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (res_out)
  );

  assign pix_i.ready      = in_ready;
  assign res_o.valid      = out_valid;
  assign res_o.red_out    = res_out.rgb.red;
  assign res_o.green_out  = res_out.rgb.green;
  assign res_o.blue_out   = res_out.rgb.blue;
  assign res_o.pixel_x    = res_out.pixel_x;
  assign res_o.pixel_y    = res_out.pixel_y;
  assign res_o.frame_last = res_out.frame_last;

  // The column count never reaches the effective width.
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(col_q) < w_eff)
    else $error("column count beyond image width");

  // A register write restarts the frame.
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (col_q == '0) && (row_q == '0))
    else $error("counters not cleared by register write");

  // After an interior pixel is accepted, the output is valid in the next cycle, holding that result or an older one.
  a_emit_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && emit) |=> res_o.valid)
    else $error("emitted result missing on output");

endmodule

// ----- rtl/lsh_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lsh_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lsh_kernel.sv -----
// Combinational 3x3 sharpening kernel on three color channels: nine times the
// center minus the eight neighbors, magnitude saturated to 255. Uses lsh_pkg.
module lsh_kernel import lsh_pkg::*; (
  input  rgb_t win_i [9],
  output rgb_t pix_o
);

  function automatic logic [ChanW-1:0] sharpen(input logic [ChanW-1:0] c,
                                               input logic [ChanW-1:0] n [8]);
    logic [ChanW+3:0]        pos;
    logic [ChanW+2:0]        neg;
    logic signed [ChanW+4:0] diff;
    logic [ChanW+4:0]        mag;
    pos = {1'b0, c, 3'b000} + (ChanW + 4)'(c);
    neg = (((ChanW + 3)'(n[0]) + (ChanW + 3)'(n[1])) +
           ((ChanW + 3)'(n[2]) + (ChanW + 3)'(n[3]))) +
          (((ChanW + 3)'(n[4]) + (ChanW + 3)'(n[5])) +
           ((ChanW + 3)'(n[6]) + (ChanW + 3)'(n[7])));
    diff = signed'((ChanW + 5)'(pos) - (ChanW + 5)'(neg));
    mag  = diff[ChanW+4] ? unsigned'(-diff) : unsigned'(diff);
    return (mag > (ChanW + 5)'(255)) ? ChanW'(255) : mag[ChanW-1:0];
  endfunction

  logic [ChanW-1:0] nr [8];
  logic [ChanW-1:0] ng [8];
  logic [ChanW-1:0] nb [8];

  // Neighbors are every tap but the center one (index 4).
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      nr[k] = (k < 4) ? win_i[k].red   : win_i[k+1].red;
      ng[k] = (k < 4) ? win_i[k].green : win_i[k+1].green;
      nb[k] = (k < 4) ? win_i[k].blue  : win_i[k+1].blue;
    end
    pix_o.red   = sharpen(win_i[4].red,   nr);
    pix_o.green = sharpen(win_i[4].green, ng);
    pix_o.blue  = sharpen(win_i[4].blue,  nb);
  end

endmodule

// ----- rtl/lsh_skid.sv -----
// Output register with a one-entry skid buffer for filtered results, so the
// input side keeps moving while a result waits. Uses lsh_pkg.
module lsh_skid import lsh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  lsh_result_t in_data_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output lsh_result_t out_data_o
);

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  lsh_result_t out_data_q, out_data_d;
  lsh_result_t skid_data_q, skid_data_d;
  logic        pop;

  assign pop        = out_valid_q && out_ready_i;
  assign in_ready_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_d = in_valid_i;
      out_data_d  = in_data_i;
    end else if (in_valid_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A buffered result always sits behind a result already on the output.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

endmodule
